// ===== sv/irvs_pkg.sv =====
// Package: types, constants and shared helpers for the ignition ramp valve sequencer.
`default_nettype none
package irvs_pkg;

	localparam int TW = 32;
	localparam int LONG_HOLD_MS_DEF = 10000;
	localparam int TAP_MIN_MS_DEF = 100;
	localparam int CFG_DW = 32;
	localparam int CFG_AW = 3;

	localparam logic [31:0] RAMP_LEVELS_RST = 32'hF0E1_D78C;
	localparam logic [15:0] STEP1_RST = 16'd500;
	localparam logic [15:0] STEP2_RST = 16'd2000;
	localparam logic [15:0] STEP3_RST = 16'd2500;
	localparam logic [15:0] PAUSE_RST = 16'd5000;
	localparam logic [15:0] SHORT_RST = 16'd100;
	localparam logic [15:0] LONG_RST = 16'd1000;
	localparam logic [15:0] LIMIT_RST = 16'd5000;

	typedef enum logic [2:0] {
		FN_TICK, FN_IGN_ON, FN_IGN_OFF, FN_SHORT, FN_LONG, FN_RELEASE, FN_OPEN, FN_CLOSE
	} irvs_func_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_LEVELS, REG_STEP1, REG_STEP2, REG_STEP3, REG_PAUSE, REG_SHORT, REG_LONG, REG_LIMIT
	} irvs_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_S1, PH_P1, PH_S2, PH_P2, PH_S3, PH_DONE
	} irvs_phase_t;

	typedef struct packed {
		irvs_func_t  func;
		logic        button_held;
		logic [15:0] release_ms;
	} irvs_in_t;

	typedef struct packed {
		logic       valve_on;
		logic       ignition_enabled;
		logic       warm_ready;
		logic [7:0] drive_level;
	} irvs_out_t;

	typedef struct packed {
		logic [31:0] ramp_levels;
		logic [15:0] step1;
		logic [15:0] step2;
		logic [15:0] step3;
		logic [15:0] pause;
		logic [15:0] short_b;
		logic [15:0] long_b;
		logic [15:0] limit;
	} irvs_cfg_t;

	typedef struct packed {
		logic [TW-1:0] now;
		logic          button_prev;
		logic          press_active;
		logic [TW-1:0] press_start;
		logic          long_done;
		logic          by_button;
		logic          shut_armed;
		logic [TW-1:0] shut_start;
		logic          valve;
		logic [TW-1:0] valve_start;
		logic [15:0]   valve_run;
		logic          ign;
		logic          ready;
		logic [7:0]    level;
		irvs_phase_t   phase;
		logic [8:0]    count;
		logic [TW-1:0] mark;
	} irvs_state_t;

	function automatic logic [TW-1:0] since(logic [TW-1:0] now, logic [TW-1:0] t);
		return now - t;
	endfunction

endpackage
`default_nettype wire

// ===== sv/irvs_step.sv =====
// Next-state logic for commands, button handling and the valve timer.
`default_nettype none
module irvs_step #(
	parameter int LONG_HOLD_MS = irvs_pkg::LONG_HOLD_MS_DEF,
	parameter int TAP_MIN_MS = irvs_pkg::TAP_MIN_MS_DEF
) (
	input  irvs_pkg::irvs_state_t cur,
	input  irvs_pkg::irvs_in_t    item,
	input  irvs_pkg::irvs_cfg_t   cfg,
	output irvs_pkg::irvs_state_t nxt
);
	import irvs_pkg::*;

	localparam logic [TW-1:0] LongHold = TW'(LONG_HOLD_MS);
	localparam logic [TW-1:0] TapMin = TW'(TAP_MIN_MS);

	function automatic irvs_state_t v_open(irvs_state_t s, logic [15:0] run);
		s.valve = 1'b1;
		s.valve_start = s.now;
		s.valve_run = run;
		return s;
	endfunction

	function automatic irvs_state_t v_close(irvs_state_t s);
		s.valve = 1'b0;
		s.valve_start = '0;
		s.valve_run = '0;
		return s;
	endfunction

	function automatic irvs_state_t r_start(irvs_state_t s, logic [7:0] lvl0);
		s.phase = PH_S1;
		s.count = {1'b0, lvl0};
		s.mark = s.now;
		s.level = lvl0;
		return s;
	endfunction

	irvs_state_t   s;
	logic          btn;
	logic          live;
	logic [TW-1:0] held;
	logic [TW-1:0] open_for;
	logic          shut;

	always_comb begin
		s = cur;
		btn = item.button_held;
		live = 1'b0;
		held = '0;
		open_for = '0;
		shut = 1'b0;
		case (item.func)
			FN_TICK: begin
				s.now = s.now + TW'(1);
				// button edge, hold and long press
				live = s.ign && s.ready;
				if (!s.button_prev && btn) begin
					s.press_active = 1'b1;
					s.press_start = s.now;
					s.long_done = 1'b0;
					s.by_button = 1'b0;
					if (live) begin
						s = v_open(s, 16'd0);
						s.by_button = 1'b1;
					end
				end
				if (s.press_active && btn) begin
					held = since(s.now, s.press_start);
					live = s.ign && s.ready;
					if (live && !s.by_button) begin
						s = v_open(s, 16'd0);
						s.by_button = 1'b1;
					end else if (!live && s.by_button) begin
						s = v_close(s);
						s.by_button = 1'b0;
					end
					if (held >= LongHold && !s.long_done) begin
						s.long_done = 1'b1;
						if (s.by_button) begin
							s = v_close(s);
							s.by_button = 1'b0;
						end
						s.ign = !s.ign;
						if (s.ign && !s.ready)
							s = r_start(s, cfg.ramp_levels[7:0]);
					end
				end
				if (s.button_prev && !btn) begin
					if (s.by_button) begin
						s = v_close(s);
						s.by_button = 1'b0;
					end
					if (s.shut_armed) begin
						s.shut_armed = 1'b0;
						s.shut_start = '0;
					end
					if (s.press_active && !s.long_done) begin
						held = since(s.now, s.press_start);
						if (held >= TapMin && held < LongHold && s.ign && s.ready)
							s = v_open(s, cfg.short_b);
					end
					s.press_active = 1'b0;
					s.long_done = 1'b0;
				end
				s.button_prev = btn;
				// valve timer and safety limit
				if (s.valve) begin
					open_for = since(s.now, s.valve_start);
					if (s.valve_run != '0 && open_for >= TW'(s.valve_run)) begin
						shut = 1'b1;
					end else if (open_for >= TW'(cfg.limit)) begin
						shut = 1'b1;
						if (s.by_button && s.press_active) begin
							s.shut_armed = 1'b1;
							s.shut_start = s.now;
						end
					end
					if (shut)
						s = v_close(s);
				end
				if (s.shut_armed && s.press_active &&
				    since(s.now, s.shut_start) >= TW'(cfg.limit)) begin
					s.ign = 1'b0;
					s.shut_armed = 1'b0;
					s.shut_start = '0;
				end
			end
			FN_IGN_ON: begin
				s.ign = 1'b1;
				if (!s.ready)
					s = r_start(s, cfg.ramp_levels[7:0]);
			end
			FN_IGN_OFF: s.ign = 1'b0;
			FN_SHORT: s = v_open(s, cfg.short_b);
			FN_LONG: s = v_open(s, cfg.long_b);
			FN_RELEASE: s = v_open(s, item.release_ms);
			FN_OPEN: s = v_open(s, cfg.limit);
			FN_CLOSE: s = v_close(s);
			default: s = v_close(s);
		endcase
		nxt = s;
	end

endmodule
`default_nettype wire

// ===== sv/irvs_ramp.sv =====
// Warm-up ramp sequencing and the ignition-off clear.
`default_nettype none
module irvs_ramp (
	input  irvs_pkg::irvs_state_t cur,
	input  logic                  tick,
	input  irvs_pkg::irvs_cfg_t   cfg,
	output irvs_pkg::irvs_state_t nxt
);
	import irvs_pkg::*;

	function automatic irvs_state_t r_stage(irvs_state_t s, logic [15:0] step,
	                                        logic [7:0] last, irvs_phase_t nph);
		logic [8:0] c;
		c = s.count + 9'd1;
		if (since(s.now, s.mark) >= TW'(step)) begin
			s.count = c;
			if (c <= {1'b0, last}) begin
				s.level = c[7:0];
				s.mark = s.now;
			end else begin
				s.phase = nph;
				if (nph == PH_DONE)
					s.ready = 1'b1;
				else
					s.mark = s.now;
			end
		end
		return s;
	endfunction

	function automatic irvs_state_t r_pause(irvs_state_t s, logic [15:0] pause,
	                                        logic [7:0] prev_end, irvs_phase_t nph);
		if (since(s.now, s.mark) >= TW'(pause)) begin
			s.phase = nph;
			s.count = {1'b0, prev_end} + 9'd1;
			s.mark = s.now;
		end
		return s;
	endfunction

	irvs_state_t s;

	always_comb begin
		s = cur;
		if (tick) begin
			case (s.phase)
				PH_S1: s = r_stage(s, cfg.step1, cfg.ramp_levels[15:8], PH_P1);
				PH_P1: s = r_pause(s, cfg.pause, cfg.ramp_levels[15:8], PH_S2);
				PH_S2: s = r_stage(s, cfg.step2, cfg.ramp_levels[23:16], PH_P2);
				PH_P2: s = r_pause(s, cfg.pause, cfg.ramp_levels[23:16], PH_S3);
				PH_S3: s = r_stage(s, cfg.step3, cfg.ramp_levels[31:24], PH_DONE);
				default: s.phase = PH_IDLE;
			endcase
		end
		if (!s.ign) begin
			s.ready = 1'b0;
			s.level = '0;
			s.phase = PH_IDLE;
		end
		nxt = s;
	end

endmodule
`default_nettype wire

// ===== sv/ignition_ramp_valve_sequencer.sv =====
// Top level: input register, state update, result register and configuration registers.
//
//  channel | direction | handshake               | payload
//  in      | in        | in_valid / in_ready     | in_item  (func, button_held, release_ms)
//  out     | out       | out_valid / out_ready   | out_item (valve_on, ignition_enabled,
//          |           |                         |           warm_ready, drive_level)
//  cfg     | in        | cfg_we                  | cfg_index, cfg_wdata
//
// One item per cycle while out_ready holds; out_valid rises as the result register loads.
// The whole update of one item is one pass from the input register into the
// state and result registers. Reset clears all state and loads default config.
// A stalled result holds while one more item waits in the input register;
// in_ready drops only when both are full.
`default_nettype none
module ignition_ramp_valve_sequencer #(
	parameter int LONG_HOLD_MS = irvs_pkg::LONG_HOLD_MS_DEF,
	parameter int TAP_MIN_MS = irvs_pkg::TAP_MIN_MS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  irvs_pkg::irvs_in_t           in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output irvs_pkg::irvs_out_t          out_item,
	input  logic                         cfg_we,
	input  logic [irvs_pkg::CFG_AW-1:0]  cfg_index,
	input  logic [irvs_pkg::CFG_DW-1:0]  cfg_wdata
);
	import irvs_pkg::*;

	irvs_in_t    item_s1;
	logic        vld_s1;
	irvs_out_t   out_q;
	logic        out_vld_q;
	irvs_state_t st_q;
	irvs_state_t st_mid;
	irvs_state_t st_nxt;
	irvs_cfg_t   cfg_q;
	logic        fire;

	assign fire = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || fire;
	assign out_valid = out_vld_q;
	assign out_item = out_q;

	irvs_step #(
		.LONG_HOLD_MS(LONG_HOLD_MS),
		.TAP_MIN_MS(TAP_MIN_MS)
	) u_step (
		.cur (st_q),
		.item(item_s1),
		.cfg (cfg_q),
		.nxt (st_mid)
	);

	irvs_ramp u_ramp (
		.cur (st_mid),
		.tick(item_s1.func == FN_TICK),
		.cfg (cfg_q),
		.nxt (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			st_q <= '0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (fire)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
			if (fire)
				st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
		if (fire) begin
			out_q.valve_on <= st_nxt.valve;
			out_q.ignition_enabled <= st_nxt.ign;
			out_q.warm_ready <= st_nxt.ready;
			out_q.drive_level <= st_nxt.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_levels <= RAMP_LEVELS_RST;
			cfg_q.step1 <= STEP1_RST;
			cfg_q.step2 <= STEP2_RST;
			cfg_q.step3 <= STEP3_RST;
			cfg_q.pause <= PAUSE_RST;
			cfg_q.short_b <= SHORT_RST;
			cfg_q.long_b <= LONG_RST;
			cfg_q.limit <= LIMIT_RST;
		end else if (cfg_we) begin
			case (irvs_reg_t'(cfg_index))
				REG_LEVELS: cfg_q.ramp_levels <= cfg_wdata[31:0];
				REG_STEP1: cfg_q.step1 <= cfg_wdata[15:0];
				REG_STEP2: cfg_q.step2 <= cfg_wdata[15:0];
				REG_STEP3: cfg_q.step3 <= cfg_wdata[15:0];
				REG_PAUSE: cfg_q.pause <= cfg_wdata[15:0];
				REG_SHORT: cfg_q.short_b <= cfg_wdata[15:0];
				REG_LONG: cfg_q.long_b <= cfg_wdata[15:0];
				REG_LIMIT: cfg_q.limit <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	a_ready_needs_ign: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.ready |-> st_q.ign)
		else $error("ready set with ignition off");

	a_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_q.ignition_enabled |-> !out_q.warm_ready && out_q.drive_level == '0)
		else $error("ignition off but ramp output not cleared");

	a_fire_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_vld_q)
		else $error("processed item lost its result");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !fire |=> vld_s1 && $stable(item_s1))
		else $error("waiting item dropped or changed");

	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.func == FN_TICK |=> st_q.now == $past(st_q.now) + TW'(1))
		else $error("tick did not advance time");

endmodule
`default_nettype wire
